[src/bis_pkg.sv]
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, types and arithmetic helpers for the bilinear scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

   // Frame geometry and fixed-point format
   localparam int MAX_SRC_WIDTH  = 512;
   localparam int MAX_SRC_HEIGHT = 512;
   localparam int FRAC_BITS      = 16;

   // Field widths of the channels
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 8;
   localparam int SIZE_REG_W = 10;
   localparam int STEP_W     = 20;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 20;

   // Source index widths (an index reaches MAX - 1 at most)
   localparam int XI_W = $clog2(MAX_SRC_WIDTH);
   localparam int YI_W = $clog2(MAX_SRC_HEIGHT);

   // Effective size width and compare widths
   localparam int SZ_MAX = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
   localparam int SZ_W   = $clog2(SZ_MAX + 1);
   localparam int SZC_W  = ((SZ_W > SIZE_REG_W) ? SZ_W : SIZE_REG_W) + 1;
   localparam int LDC_W  = ((SZ_W > COORD_W) ? SZ_W : COORD_W) + 1;

   // Scaled coordinate: coordinate times step
   localparam int PROD_W = COORD_W + STEP_W;
   localparam int IP_W   = PROD_W - FRAC_BITS;
   localparam int MAG_W  = FRAC_BITS + PIX_W;

   localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0]    COORD_ONE = PROD_W'(1) << FRAC_BITS;

   // Frame banks: split by row and column parity so four neighbors read at once
   localparam int BANK_COL_W = XI_W - 1;
   localparam int BANK_ROW_W = YI_W - 1;
   localparam int BANK_AW    = BANK_COL_W + BANK_ROW_W;
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int NUM_BANKS  = 4;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_STEP_X     = 2'd2,
      CSR_STEP_Y     = 2'd3
   } csr_index_type;

   // Input item payload, first field in the highest bits
   typedef struct packed {
      logic [PIX_W-1:0]   pixel_in;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } req_word_type;

   // Result item payload, first field in the highest bits
   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic [PIX_W-1:0]   pixel_out;
   } rsp_word_type;

   // Configuration as seen by the datapath, sizes already clamped
   typedef struct packed {
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic [SZ_W-1:0]   width;
      logic [SZ_W-1:0]   height;
      logic [SZ_W-1:0]   wm1;
      logic [SZ_W-1:0]   wm2;
      logic [SZ_W-1:0]   hm1;
      logic [SZ_W-1:0]   hm2;
   } cfg_type;

   // Coordinate unit to frame store
   typedef struct packed {
      logic                 is_req;
      logic                 load_ok;
      req_word_type         word;
      logic [XI_W-1:0]      xi;
      logic [YI_W-1:0]      yi;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } frame_req_type;

   // Frame store to blend unit
   typedef struct packed {
      logic                 is_req;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
      logic [PIX_W-1:0]     lt;
      logic [PIX_W-1:0]     rt;
      logic [PIX_W-1:0]     lb;
      logic [PIX_W-1:0]     rb;
   } nbr_type;

   // Clamp a size register to [2, maxv]
   function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v,
                                                  input int maxv);
      logic [SZC_W-1:0] ve;
      ve = SZC_W'(v);
      if (ve < SZC_W'(2)) begin
         return SZ_W'(2);
      end else if (ve > SZC_W'(maxv)) begin
         return SZ_W'(maxv);
      end
      return SZ_W'(ve);
   endfunction

   // frac * d / 2^FRAC_BITS, rounded to nearest, ties to even
   function automatic logic signed [9:0] rnd_mul(input logic [FRAC_BITS-1:0] frac,
                                                 input logic signed [9:0] d);
      logic                 neg;
      logic [9:0]           dabs;
      logic [MAG_W-1:0]     mag;
      logic [PIX_W-1:0]     q;
      logic [FRAC_BITS-1:0] r;
      logic [PIX_W:0]       qr;
      logic signed [9:0]    mv;
      neg  = d[9];
      dabs = neg ? 10'(-d) : 10'(d);
      mag  = MAG_W'(dabs[PIX_W-1:0]) * MAG_W'(frac);
      q    = mag[MAG_W-1:FRAC_BITS];
      r    = mag[FRAC_BITS-1:0];
      qr   = {1'b0, q} + (PIX_W+1)'((r > FRAC_HALF) || ((r == FRAC_HALF) && q[0]));
      mv   = 10'(qr);
      return neg ? -mv : mv;
   endfunction

endpackage

[src/bis_ram.sv]
// ----------------------------------------------------------------------------
// bis_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bis_coord.sv]
// ----------------------------------------------------------------------------
// bis_coord
// Maps a destination pixel into the source grid: scale, step back at the
// edge, clamp. Three stages; loads ride along to keep item order.
// ----------------------------------------------------------------------------
module bis_coord (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  logic                   in_kind,
   input  bis_pkg::req_word_type  in_word,
   input  bis_pkg::cfg_type       cfg,
   output logic                   out_vld,
   output bis_pkg::frame_req_type out_req
);

   typedef struct packed {
      logic                  kind;
      bis_pkg::req_word_type word;
   } s1_type;

   typedef struct packed {
      logic                        kind;
      logic                        load_ok;
      bis_pkg::req_word_type       word;
      logic [bis_pkg::PROD_W-1:0]  sx;
      logic [bis_pkg::PROD_W-1:0]  sy;
   } s2_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff, s3_in, s3_ff;
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff;

   logic [bis_pkg::PROD_W-1:0] last_x, last_y;
   logic [bis_pkg::IP_W-1:0]   ip_x, ip_y;
   logic                       clamp_x, clamp_y;

   // Stage 1: capture the item
   always_comb begin
      s1_in.kind = in_kind;
      s1_in.word = in_word;
   end

   // Stage 2: scale both coordinates, check load bounds
   always_comb begin
      s2_in.kind    = s1_ff.kind;
      s2_in.word    = s1_ff.word;
      s2_in.load_ok = (bis_pkg::LDC_W'(s1_ff.word.col) < bis_pkg::LDC_W'(cfg.width)) &&
                      (bis_pkg::LDC_W'(s1_ff.word.row) < bis_pkg::LDC_W'(cfg.height));
      s2_in.sx      = bis_pkg::PROD_W'(s1_ff.word.col) * bis_pkg::PROD_W'(cfg.step_x);
      s2_in.sy      = bis_pkg::PROD_W'(s1_ff.word.row) * bis_pkg::PROD_W'(cfg.step_y);
   end

   // Stage 3: step back one unit at or past the last column or row
   always_comb begin
      last_x = bis_pkg::PROD_W'(cfg.wm1) << bis_pkg::FRAC_BITS;
      last_y = bis_pkg::PROD_W'(cfg.hm1) << bis_pkg::FRAC_BITS;
      s3_in  = s2_ff;
      if (s2_ff.sx >= last_x) begin
         s3_in.sx = s2_ff.sx - bis_pkg::COORD_ONE;
      end
      if (s2_ff.sy >= last_y) begin
         s3_in.sy = s2_ff.sy - bis_pkg::COORD_ONE;
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   // Clamp an integer part that is still beyond the last pair
   always_comb begin
      ip_x    = s3_ff.sx[bis_pkg::PROD_W-1:bis_pkg::FRAC_BITS];
      ip_y    = s3_ff.sy[bis_pkg::PROD_W-1:bis_pkg::FRAC_BITS];
      clamp_x = ip_x > bis_pkg::IP_W'(cfg.wm2);
      clamp_y = ip_y > bis_pkg::IP_W'(cfg.hm2);

      out_req.is_req  = s3_ff.kind;
      out_req.load_ok = s3_ff.load_ok;
      out_req.word    = s3_ff.word;
      out_req.xi      = clamp_x ? bis_pkg::XI_W'(cfg.wm2) : ip_x[bis_pkg::XI_W-1:0];
      out_req.yi      = clamp_y ? bis_pkg::YI_W'(cfg.hm2) : ip_y[bis_pkg::YI_W-1:0];
      out_req.fx      = clamp_x ? '1 : s3_ff.sx[bis_pkg::FRAC_BITS-1:0];
      out_req.fy      = clamp_y ? '1 : s3_ff.sy[bis_pkg::FRAC_BITS-1:0];
   end

   assign out_vld = s3_vld_ff;

endmodule

[src/bis_frame.sv]
// ----------------------------------------------------------------------------
// bis_frame
// Source frame store in four parity banks. Loads write one bank; a request
// reads all four neighbors in the same cycle.
// ----------------------------------------------------------------------------
module bis_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  bis_pkg::frame_req_type in_req,
   output logic                   out_vld,
   output bis_pkg::nbr_type       out_nbr
);

   typedef struct packed {
      logic                          is_req;
      logic [bis_pkg::COORD_W-1:0]   row;
      logic [bis_pkg::COORD_W-1:0]   col;
      logic [bis_pkg::FRAC_BITS-1:0] fx;
      logic [bis_pkg::FRAC_BITS-1:0] fy;
      logic                          yi0;
      logic                          xi0;
   } meta_type;

   meta_type meta_in, meta_ff;
   logic     vld_ff;

   logic [bis_pkg::BANK_AW-1:0] wr_addr;
   logic [bis_pkg::PIX_W-1:0]   bank_q [bis_pkg::NUM_BANKS];

   // Load address inside a bank
   assign wr_addr = {in_req.word.row[bis_pkg::YI_W-1:1], in_req.word.col[bis_pkg::XI_W-1:1]};

   // One bank per row and column parity
   for (genvar gb = 0; gb < bis_pkg::NUM_BANKS; gb++) begin : g_bank
      localparam int BY = gb / 2;
      localparam int BX = gb % 2;

      logic                           wr_en, rd_en;
      logic [bis_pkg::BANK_ROW_W-1:0] rd_row;
      logic [bis_pkg::BANK_COL_W-1:0] rd_col;

      // Bank row is yi or yi+1, whichever has this parity
      always_comb begin
         wr_en  = in_vld && !in_req.is_req && in_req.load_ok &&
                  (in_req.word.row[0] == 1'(BY)) && (in_req.word.col[0] == 1'(BX));
         rd_en  = in_vld && in_req.is_req;
         rd_row = in_req.yi[bis_pkg::YI_W-1:1] +
                  bis_pkg::BANK_ROW_W'(in_req.yi[0] && (BY == 0));
         rd_col = in_req.xi[bis_pkg::XI_W-1:1] +
                  bis_pkg::BANK_COL_W'(in_req.xi[0] && (BX == 0));
      end

      bis_ram #(
         .WIDTH (bis_pkg::PIX_W),
         .DEPTH (bis_pkg::BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (in_req.word.pixel_in),
         .rd_en   (rd_en),
         .rd_addr ({rd_row, rd_col}),
         .rd_data (bank_q[gb])
      );
   end

   // Carry the request alongside the read
   always_comb begin
      meta_in.is_req = in_req.is_req;
      meta_in.row    = in_req.word.row;
      meta_in.col    = in_req.word.col;
      meta_in.fx     = in_req.fx;
      meta_in.fy     = in_req.fy;
      meta_in.yi0    = in_req.yi[0];
      meta_in.xi0    = in_req.xi[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

   // Route banks back to left/right, top/bottom
   always_comb begin
      out_nbr.is_req = meta_ff.is_req;
      out_nbr.row    = meta_ff.row;
      out_nbr.col    = meta_ff.col;
      out_nbr.fx     = meta_ff.fx;
      out_nbr.fy     = meta_ff.fy;
      out_nbr.lt     = bank_q[{meta_ff.yi0, meta_ff.xi0}];
      out_nbr.rt     = bank_q[{meta_ff.yi0, ~meta_ff.xi0}];
      out_nbr.lb     = bank_q[{~meta_ff.yi0, meta_ff.xi0}];
      out_nbr.rb     = bank_q[{~meta_ff.yi0, ~meta_ff.xi0}];
   end

   assign out_vld = vld_ff;

endmodule

[src/bis_blend.sv]
// ----------------------------------------------------------------------------
// bis_blend
// Two-stage blend: vertical pair of lerps, then one horizontal lerp.
// Drops loads; emits one result per request.
// ----------------------------------------------------------------------------
module bis_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  bis_pkg::nbr_type      in_nbr,
   output logic                  out_vld,
   output bis_pkg::rsp_word_type out_word
);

   typedef struct packed {
      logic [bis_pkg::COORD_W-1:0]   row;
      logic [bis_pkg::COORD_W-1:0]   col;
      logic [bis_pkg::FRAC_BITS-1:0] fx;
      logic [bis_pkg::PIX_W-1:0]     m1;
      logic [bis_pkg::PIX_W-1:0]     m2;
   } mid_type;

   mid_type           mid_in, mid_ff;
   logic              vld_in, vld_ff;
   logic signed [9:0] d1, d2, dh, m1_w, m2_w, p_w;

   // Vertical blend of left and right columns
   always_comb begin
      d1   = $signed({2'b00, in_nbr.lb}) - $signed({2'b00, in_nbr.lt});
      d2   = $signed({2'b00, in_nbr.rb}) - $signed({2'b00, in_nbr.rt});
      m1_w = $signed({2'b00, in_nbr.lt}) + bis_pkg::rnd_mul(in_nbr.fy, d1);
      m2_w = $signed({2'b00, in_nbr.rt}) + bis_pkg::rnd_mul(in_nbr.fy, d2);

      mid_in.row = in_nbr.row;
      mid_in.col = in_nbr.col;
      mid_in.fx  = in_nbr.fx;
      mid_in.m1  = m1_w[bis_pkg::PIX_W-1:0];
      mid_in.m2  = m2_w[bis_pkg::PIX_W-1:0];
      vld_in     = in_vld && in_nbr.is_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

   // Horizontal blend, saturate to a byte
   always_comb begin
      dh  = $signed({2'b00, mid_ff.m2}) - $signed({2'b00, mid_ff.m1});
      p_w = $signed({2'b00, mid_ff.m1}) + bis_pkg::rnd_mul(mid_ff.fx, dh);

      out_word.out_row = mid_ff.row;
      out_word.out_col = mid_ff.col;
      if (p_w < 10'sd0) begin
         out_word.pixel_out = '0;
      end else if (p_w > 10'sd255) begin
         out_word.pixel_out = '1;
      end else begin
         out_word.pixel_out = p_w[bis_pkg::PIX_W-1:0];
      end
   end

   assign out_vld = vld_ff;

endmodule

[src/bis_fifo.sv]
// ----------------------------------------------------------------------------
// bis_fifo
// Result queue between the blend pipeline and the result channel.
// The caller never writes it when full.
// ----------------------------------------------------------------------------
module bis_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  bis_pkg::rsp_word_type wr_data,
   input  logic                  rd_en,
   output logic                  not_empty,
   output bis_pkg::rsp_word_type rd_data
);

   bis_pkg::rsp_word_type       mem_ff [bis_pkg::FIFO_DEPTH];
   logic [bis_pkg::FIFO_AW-1:0] wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [bis_pkg::CNT_W-1:0]   count_in, count_ff;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

endmodule

[src/bilinear_image_scaler.sv]
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Grayscale bilinear scaler with a banked source frame store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items in. req_tuser = 0 loads pixel_in at (row, col) into the
//   frame store (ignored outside the configured source size); req_tuser = 1
//   asks for the destination pixel at (row, col). Only requests give a result
//   on rsp_*, in the order they were accepted.
//   csr_* writes src_width, src_height, step_x, step_y; write it only while the
//   block is idle. csr_ready is high whenever reset is low.
// Timing:
//   One item per clock while req_tready is high. An accepted request passes
//   through capture, multiply, edge step-back, clamp plus bank read, vertical
//   blend and horizontal blend into the result queue. The four parity banks
//   give all four neighbors in a single read.
// Stall:
//   The pipeline never stops; results collect in an 8-entry queue. req_tready
//   drops while 8 requests are accepted and not yet taken from rsp_*.
// Reset:
//   Registers return to 512 x 512 and step 0.5; the queue empties; req_tready
//   and csr_ready stay low. The frame store is not cleared: load a pixel
//   before any request reads it.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // row, col, pixel_in
   input  logic                             req_tuser,  // kind
   // result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // pixel_out, out_row, out_col
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bis_pkg::cfg_type       cfg_in, cfg_ff;
   logic [bis_pkg::SZ_W-1:0] new_size;
   logic [bis_pkg::CNT_W-1:0] pend_in, pend_ff;

   logic                   req_acc, rsp_acc, req_new;
   logic                   crd_vld, frm_vld, bld_vld;
   bis_pkg::frame_req_type crd_req;
   bis_pkg::nbr_type       frm_nbr;
   bis_pkg::rsp_word_type  bld_word, fifo_word;

   assign csr_ready = !reset;

   // Register writes, sizes stored clamped with their offsets
   always_comb begin
      cfg_in   = cfg_ff;
      new_size = '0;
      if (csr_valid) begin
         unique case (bis_pkg::csr_index_type'(csr_addr))
            bis_pkg::CSR_SRC_WIDTH: begin
               new_size     = bis_pkg::clamp_size(csr_wdata[bis_pkg::SIZE_REG_W-1:0],
                                                  bis_pkg::MAX_SRC_WIDTH);
               cfg_in.width = new_size;
               cfg_in.wm1   = new_size - 1'b1;
               cfg_in.wm2   = new_size - 2'd2;
            end
            bis_pkg::CSR_SRC_HEIGHT: begin
               new_size      = bis_pkg::clamp_size(csr_wdata[bis_pkg::SIZE_REG_W-1:0],
                                                   bis_pkg::MAX_SRC_HEIGHT);
               cfg_in.height = new_size;
               cfg_in.hm1    = new_size - 1'b1;
               cfg_in.hm2    = new_size - 2'd2;
            end
            bis_pkg::CSR_STEP_X: cfg_in.step_x = csr_wdata;
            bis_pkg::CSR_STEP_Y: cfg_in.step_y = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_WIDTH);
         cfg_ff.wm1    <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_WIDTH) - 1'b1;
         cfg_ff.wm2    <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_WIDTH) - 2'd2;
         cfg_ff.height <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_HEIGHT);
         cfg_ff.hm1    <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_HEIGHT) - 1'b1;
         cfg_ff.hm2    <= bis_pkg::clamp_size(10'd512, bis_pkg::MAX_SRC_HEIGHT) - 2'd2;
         cfg_ff.step_x <= 20'd32768;
         cfg_ff.step_y <= 20'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Count requests in flight so the result queue never overflows
   assign req_tready = !reset && (pend_ff != bis_pkg::CNT_W'(bis_pkg::FIFO_DEPTH));
   assign req_acc    = req_tvalid && req_tready;
   assign req_new    = req_acc && req_tuser;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({req_new, rsp_acc})
         2'b10:   pend_in = pend_ff + 1'b1;
         2'b01:   pend_in = pend_ff - 1'b1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   bis_coord u_coord (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_acc),
      .in_kind (req_tuser),
      .in_word (bis_pkg::req_word_type'(req_tdata)),
      .cfg     (cfg_ff),
      .out_vld (crd_vld),
      .out_req (crd_req)
   );

   bis_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (crd_vld),
      .in_req  (crd_req),
      .out_vld (frm_vld),
      .out_nbr (frm_nbr)
   );

   bis_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (frm_vld),
      .in_nbr   (frm_nbr),
      .out_vld  (bld_vld),
      .out_word (bld_word)
   );

   bis_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (bld_vld),
      .wr_data   (bld_word),
      .rd_en     (rsp_acc),
      .not_empty (rsp_tvalid),
      .rd_data   (fifo_word)
   );

   assign rsp_tdata = 32'(fifo_word);

endmodule

[src/bis_checker.sv]
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks for the bilinear scaler, bound to the top level.
// ----------------------------------------------------------------------------
module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Come out of reset empty and ready
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid && req_tready)
      else $error("not empty and ready after reset");

   // A result appearing on an empty channel comes from an earlier accepted request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser, 6))
      else $error("result without a matching request");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);
